/* rtl/pcx_rle_image_decoder_defines.svh */
// ----------------------------------------------------------------------------
// PCX RLE decoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_IMAGE_DECODER_DEFINES_SVH
`define PCX_RLE_IMAGE_DECODER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define PCX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define PCX_ASSERT_NEVER(name, cond, msg) \
  `PCX_ASSERT(name, !(cond), msg)

`endif

/* rtl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Types, constants and controller/datapath link structs.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int unsigned COL_W  = 13;
  localparam int unsigned ADDR_W = 20;

  localparam logic [10:0] MAX_WIDTH    = 11'd1024;
  localparam logic [10:0] MAX_HEIGHT   = 11'd1024;
  localparam int unsigned PALETTE_SIZE = 256;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd320;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd200;
  localparam logic [11:0] RST_LINE_BYTES   = 12'd320;

  localparam logic [1:0] RUN_PREFIX     = 2'b11;
  localparam logic [7:0] PALETTE_MARKER = 8'd12;
  localparam logic [7:0] LAST_ENTRY     = 8'(PALETTE_SIZE - 1);

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LINE_BYTES   = 2'd2;

  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef enum logic [2:0] {
    ST_PIXEL,
    ST_VALUE,
    ST_RUN,
    ST_MARKER,
    ST_PALETTE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_value;
    logic [7:0]        palette_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [11:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic load_run;
    logic load_value;
    logic pix_step;
    logic pix_literal;
    logic pal_start;
    logic pal_byte;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic slot_free;
    logic no_rows;
    logic byte_prefix;
    logic byte_marker;
    logic remaining_zero;
    logic run_end;
    logic row_done;
    logic last_row;
    logic pal_emit;
    logic pal_final;
  } sts_t;

endpackage

/* rtl/pcxrle_stream_if.sv */
// ----------------------------------------------------------------------------
// PCX RLE stream interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface pcxrle_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/pcxrle_dp.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Config registers, position counters, run/palette holds, result register.
// ----------------------------------------------------------------------------
`include "pcx_rle_image_decoder_defines.svh"

module pcxrle_dp import pcxrle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           in_byte_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  pcxrle_stream_if.sink        cfg_i,
  pcxrle_stream_if.source      out_o
);

  logic [10:0]       width_q, height_q;
  logic [11:0]       line_bytes_q;
  logic [COL_W-1:0]  column_q, column_d;
  logic [10:0]       row_q, row_d;
  logic [ADDR_W-1:0] row_base_q, row_base_d;
  logic [5:0]        remaining_q, remaining_d;
  logic [7:0]        value_q, value_d;
  logic [7:0]        entry_q, entry_d;
  logic [1:0]        step_q, step_d;
  logic [7:0]        red_q, red_d;
  logic [7:0]        green_q, green_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [10:0]      eff_w, eff_h;
  logic             cfg_hit;
  logic [5:0]       cnt;
  logic [7:0]       pix_val;
  logic             col_in_w;
  logic [COL_W-1:0] col_end;
  logic             run_end;
  logic             row_done;
  logic             pix_last;

  assign eff_w = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
  assign eff_h = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid && (cfg_i.payload.reg_index == REG_IMAGE_WIDTH ||
                                   cfg_i.payload.reg_index == REG_IMAGE_HEIGHT ||
                                   cfg_i.payload.reg_index == REG_LINE_BYTES);

  assign cnt      = cmd_i.pix_literal ? 6'd1 : remaining_q;
  assign pix_val  = cmd_i.pix_literal ? in_byte_i : value_q;
  assign col_in_w = column_q < COL_W'(eff_w);
  assign col_end  = column_q + COL_W'(cnt);
  assign run_end  = cmd_i.pix_literal || (remaining_q == 6'd1) || !col_in_w;
  assign row_done = col_end >= COL_W'(line_bytes_q);
  // last kept pixel of a run: run exhausted or next column falls outside the image
  assign pix_last = cmd_i.pix_literal || (remaining_q == 6'd1) ||
                    (column_q + COL_W'(1) == COL_W'(eff_w));

  always_comb begin
    sts_o                = '0;
    sts_o.restart        = cfg_hit;
    sts_o.slot_free      = !out_valid_q || out_o.ready;
    sts_o.no_rows        = (line_bytes_q == 12'd0) || (row_q >= eff_h);
    sts_o.byte_prefix    = in_byte_i[7:6] == RUN_PREFIX;
    sts_o.byte_marker    = in_byte_i == PALETTE_MARKER;
    sts_o.remaining_zero = remaining_q == 6'd0;
    sts_o.run_end        = run_end;
    sts_o.row_done       = row_done;
    sts_o.last_row       = ({1'b0, row_q} + 12'd1) >= {1'b0, eff_h};
    sts_o.pal_emit       = step_q == 2'd2;
    sts_o.pal_final      = entry_q == LAST_ENTRY;
  end

  always_comb begin
    column_d    = column_q;
    row_d       = row_q;
    row_base_d  = row_base_q;
    remaining_d = remaining_q;
    value_d     = value_q;
    entry_d     = entry_q;
    step_d      = step_q;
    red_d       = red_q;
    green_d     = green_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    if (cmd_i.load_run) begin
      remaining_d = in_byte_i[5:0];
    end
    if (cmd_i.load_value) begin
      value_d = in_byte_i;
    end

    if (cmd_i.pix_step) begin
      if (col_in_w) begin
        out_valid_d         = 1'b1;
        out_d               = '0;
        out_d.kind          = KIND_PIXEL;
        out_d.pixel_address = row_base_q + ADDR_W'(column_q);
        out_d.pixel_value   = pix_val;
        out_d.last          = pix_last;
      end
      if (run_end) begin
        if (row_done) begin
          column_d   = '0;
          row_d      = row_q + 11'd1;
          row_base_d = row_base_q + ADDR_W'(eff_w);
        end else begin
          column_d = col_end;
        end
      end else begin
        column_d    = column_q + COL_W'(1);
        remaining_d = remaining_q - 6'd1;
      end
    end

    if (cmd_i.emit_end) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.kind  = KIND_END;
      out_d.last  = 1'b1;
    end

    if (cmd_i.pal_start) begin
      entry_d = '0;
      step_d  = '0;
    end

    if (cmd_i.pal_byte) begin
      unique case (step_q)
        2'd0: begin
          red_d  = in_byte_i;
          step_d = 2'd1;
        end
        2'd1: begin
          green_d = in_byte_i;
          step_d  = 2'd2;
        end
        default: begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.kind          = KIND_PALETTE;
          out_d.palette_index = entry_q;
          out_d.red           = red_q;
          out_d.green         = green_q;
          out_d.blue          = in_byte_i;
          out_d.last          = 1'b1;
          step_d              = 2'd0;
          entry_d             = entry_q + 8'd1;
        end
      endcase
    end

    if (cfg_hit) begin
      column_d    = '0;
      row_d       = '0;
      row_base_d  = '0;
      remaining_d = '0;
      entry_d     = '0;
      step_d      = '0;
      red_d       = '0;
      green_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= RST_IMAGE_WIDTH;
      height_q     <= RST_IMAGE_HEIGHT;
      line_bytes_q <= RST_LINE_BYTES;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.reg_index)
        REG_IMAGE_WIDTH:  width_q      <= cfg_i.payload.wdata[10:0];
        REG_IMAGE_HEIGHT: height_q     <= cfg_i.payload.wdata[10:0];
        REG_LINE_BYTES:   line_bytes_q <= cfg_i.payload.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      row_base_q  <= '0;
      remaining_q <= '0;
      entry_q     <= '0;
      step_q      <= '0;
      red_q       <= '0;
      green_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      column_q    <= column_d;
      row_q       <= row_d;
      row_base_q  <= row_base_d;
      remaining_q <= remaining_d;
      entry_q     <= entry_d;
      step_q      <= step_d;
      red_q       <= red_d;
      green_q     <= green_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    out_q   <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `PCX_ASSERT(a_end_is_last, out_valid_q && out_q.kind == KIND_END |-> out_q.last, "end result without last")
  `PCX_ASSERT(a_row_bound, row_q <= eff_h, "row counter beyond image height")

endmodule

/* rtl/pcxrle_ctrl.sv */
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Phase sequencing: pixels, run value, run emission, marker, palette, done.
// ----------------------------------------------------------------------------
`include "pcx_rle_image_decoder_defines.svh"

module pcxrle_ctrl import pcxrle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_PIXEL: begin
        if (sts_i.no_rows) begin
          state_d = ST_MARKER;
        end else if (accept) begin
          if (sts_i.byte_prefix) begin
            state_d = ST_VALUE;
          end else if (sts_i.row_done && sts_i.last_row) begin
            state_d = ST_MARKER;
          end
        end
      end
      ST_VALUE: begin
        if (accept) begin
          state_d = sts_i.remaining_zero ? ST_PIXEL : ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.slot_free && sts_i.run_end) begin
          state_d = (sts_i.row_done && sts_i.last_row) ? ST_MARKER : ST_PIXEL;
        end
      end
      ST_MARKER: begin
        if (accept) begin
          state_d = sts_i.byte_marker ? ST_PALETTE : ST_DONE;
        end
      end
      ST_PALETTE: begin
        if (accept && sts_i.pal_emit && sts_i.pal_final) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_DONE;
      default: state_d = ST_PIXEL;
    endcase
    if (sts_i.restart) begin
      state_d = ST_PIXEL;
    end
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_PIXEL: begin
        in_ready_o = sts_i.slot_free && !sts_i.no_rows;
        if (in_valid_i && in_ready_o) begin
          if (sts_i.byte_prefix) begin
            cmd_o.load_run = 1'b1;
          end else begin
            cmd_o.pix_step    = 1'b1;
            cmd_o.pix_literal = 1'b1;
          end
        end
      end
      ST_VALUE: begin
        in_ready_o       = sts_i.slot_free;
        cmd_o.load_value = in_valid_i && in_ready_o;
      end
      ST_RUN: begin
        cmd_o.pix_step = sts_i.slot_free;
      end
      ST_MARKER: begin
        in_ready_o = sts_i.slot_free;
        if (in_valid_i && in_ready_o) begin
          cmd_o.pal_start = sts_i.byte_marker;
          cmd_o.emit_end  = !sts_i.byte_marker;
        end
      end
      ST_PALETTE: begin
        in_ready_o     = sts_i.slot_free;
        cmd_o.pal_byte = in_valid_i && in_ready_o;
      end
      ST_DONE: begin
        in_ready_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PIXEL;
    end else begin
      state_q <= state_d;
    end
  end

  `PCX_ASSERT(a_done_exit, state_q != ST_DONE && $past(state_q == ST_DONE) |-> $past(sts_i.restart), "left done without register write")
  `PCX_ASSERT_NEVER(a_run_nonzero, state_q == ST_RUN && sts_i.remaining_zero, "run emission with zero count")

endmodule

/* rtl/pcx_rle_image_decoder.sv */
// ----------------------------------------------------------------------------
// PCX RLE image decoder
// 8-bit single-plane PCX run-length decoder with palette trailer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | transaction
//  in_i    | in  | data_byte                                 | one compressed byte
//  out_o   | out | kind, pixel_address, pixel_value,         | one result
//          |     | palette_index, red, green, blue, last     |
//  cfg_i   | in  | reg_index, wdata                          | one register write
//
//  A run takes its prefix byte, then its value byte, then emits one result per
//  kept pixel and steps over any pixels dropped past the image width; one
//  result register sets the pace.
//  Reset restores 320 x 200, 320 bytes per line, decode at row 0.
//  A stalled result holds off further input until done; cfg is always ready.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder import pcxrle_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pcxrle_stream_if.sink   in_i,
  pcxrle_stream_if.source out_o,
  pcxrle_stream_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  pcxrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcxrle_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_i.payload.data_byte),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule
